// ===== hw/rtl/base16_base64_decoder_core_assert.svh =====
// Assertion macros for the base16/base64 decoder core.
`ifndef BASE16_BASE64_DECODER_CORE_ASSERT_SVH
`define BASE16_BASE64_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bbd_pkg.sv =====
// Shared types, constants and character classifiers for the decoder.
`timescale 1ns / 1ps

package bbd_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int OUT_COUNT_W = 32;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic MODE_HEX = 1'b0;
	localparam logic MODE_B64 = 1'b1;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// One queued unit of work: up to three bytes, packed high byte first.
	typedef struct packed {
		logic [23:0]            data;
		logic [1:0]             nbytes;   // zero: single result without a byte
		logic                   done;
		logic                   err;
		logic [OUT_COUNT_W-1:0] count;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h41 + 8'd10)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h61 + 8'd10)};
		return r;
	endfunction

	// {valid, sextet}
	function automatic logic [6:0] b64_value(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		if (c >= 8'h41 && c <= 8'h5A)
			r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A)
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B)
			r = {1'b1, 6'd62};
		else if (c == 8'h2F)
			r = {1'b1, 6'd63};
		return r;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
			input logic [1:0] n);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + (COUNT_WIDTH+1)'(n);
		return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
	endfunction

endpackage

// ===== hw/rtl/bbd_front.sv =====
// Front end: accepts characters, classifies them, keeps text state, queues jobs.
`timescale 1ns / 1ps

module bbd_front import bbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       end_of_text,
	input  qstat_t     qstat,
	output logic       push,
	output job_t       push_job
);

	logic                   mode_q;
	logic [1:0]             phase_q, phase_d;
	logic [23:0]            acc_q, acc_d;
	logic                   pad_q, pad_d;
	logic                   err_q, err_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

	logic        accept;
	logic [4:0]  hv;
	logic [6:0]  bv;
	logic [23:0] acc_shift;
	logic [COUNT_WIDTH-1:0] cnt_flush;

	assign in_ready  = !qstat.full;
	assign accept    = in_valid && in_ready;
	assign hv        = hex_value(symbol);
	assign bv        = b64_value(symbol);
	assign acc_shift = {acc_q[17:0], bv[5:0]};

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		pad_d     = pad_q;
		err_d     = err_q;
		cnt_d     = cnt_q;
		push      = 1'b0;
		push_job  = '0;
		cnt_flush = cnt_q;
		if (accept) begin
			priority if (end_of_text) begin
				push_job.done = 1'b1;
				push_job.err  = err_q;
				if (!err_q) begin
					if (mode_q == MODE_HEX) begin
						if (phase_q != 2'd0)
							push_job.err = 1'b1;
					end else begin
						unique case (phase_q)
							2'd1: push_job.err = 1'b1;
							2'd2: begin
								push_job.nbytes = 2'd1;
								push_job.data   = {acc_q[11:4], 16'h0000};
							end
							2'd3: begin
								push_job.nbytes = 2'd2;
								push_job.data   = {acc_q[17:10], acc_q[9:2], 8'h00};
							end
							default: ;
						endcase
					end
				end
				cnt_flush      = sat_add(cnt_q, push_job.nbytes);
				push_job.count = OUT_COUNT_W'(cnt_flush);
				push           = 1'b1;
				phase_d        = '0;
				acc_d          = '0;
				pad_d          = 1'b0;
				err_d          = 1'b0;
				cnt_d          = '0;
			end else if (err_q || pad_q) begin
				// dropped until end of text
			end else if (mode_q == MODE_HEX) begin
				if (!hv[4]) begin
					err_d = 1'b1;
				end else if (phase_q == 2'd0) begin
					acc_d   = {20'h0, hv[3:0]};
					phase_d = 2'd1;
				end else begin
					push_job.nbytes = 2'd1;
					push_job.data   = {acc_q[3:0], hv[3:0], 16'h0000};
					push            = 1'b1;
					cnt_d           = sat_add(cnt_q, 2'd1);
					phase_d         = '0;
					acc_d           = '0;
				end
			end else if (symbol == CHAR_PAD) begin
				pad_d = 1'b1;
			end else if (!bv[6]) begin
				err_d = 1'b1;
			end else if (phase_q != 2'd3) begin
				acc_d   = acc_shift;
				phase_d = phase_q + 2'd1;
			end else begin
				push_job.nbytes = 2'd3;
				push_job.data   = acc_shift;
				push            = 1'b1;
				cnt_d           = sat_add(cnt_q, 2'd3);
				phase_d         = '0;
				acc_d           = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HEX;
			phase_q <= '0;
			acc_q   <= '0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cfg_wr_en)
				mode_q <= cfg_wr_data;
			phase_q <= phase_d;
			acc_q   <= acc_d;
			pad_q   <= pad_d;
			err_q   <= err_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== hw/rtl/bbd_queue.sv =====
// Short job queue between front and back.
`timescale 1ns / 1ps

module bbd_queue import bbd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	input  logic   pop,
	output job_t   head,
	output qstat_t stat
);

	job_t             slot_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     fill_q;
	logic             do_push, do_pop;

	assign stat.full  = (fill_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (fill_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + QAW'(1);
			if (do_pop)
				rptr_q <= rptr_q + QAW'(1);
			fill_q <= fill_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/bbd_back.sv =====
// Back end: unpacks queued jobs into one result per cycle while out_ready allows, behind an output register.
`timescale 1ns / 1ps

module bbd_back import bbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  job_t                   head,
	input  qstat_t                 qstat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             data_byte,
	output logic                   has_byte,
	output logic                   run_last,
	output logic                   text_done,
	output logic                   decode_error,
	output logic [OUT_COUNT_W-1:0] byte_count
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load, last, has;
	logic [7:0] sel;

	assign has  = (head.nbytes != 2'd0);
	assign last = !has || (idx_q == head.nbytes - 2'd1);
	assign load = !qstat.empty && (!valid_q || out_ready);
	assign pop  = load && last;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel = head.data[23:16];
			2'd1:    sel = head.data[15:8];
			default: sel = head.data[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			data_byte    <= has ? sel : 8'h00;
			has_byte     <= has;
			run_last     <= last;
			text_done    <= head.done;
			decode_error <= last && head.err;
			byte_count   <= (last && head.done) ? head.count : '0;
		end
	end

	assign out_valid = valid_q;

endmodule

// ===== hw/rtl/base16_base64_decoder_core.sv =====
// Top level of the base16/base64 decoder core.
//
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_wr_en               | cfg_wr_data (decode_mode)
//  in      | in        | in_valid / in_ready     | symbol, end_of_text
//  out     | out       | out_valid / out_ready   | data_byte .. byte_count
//
// One character per cycle is accepted while the job queue has room.
// The back end emits one result per cycle while out_ready allows: a base64 quantum gives three,
// a hex pair one, an end of text one or two; the output rate limits a long stream.
// A four-entry job queue plus the output register absorb stalls on out_ready.
// Reset clears text state, the queue and the output valid flag; mode resets to hex.
`timescale 1ns / 1ps
`include "base16_base64_decoder_core_assert.svh"

module base16_base64_decoder_core import bbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             symbol,
	input  logic                   end_of_text,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             data_byte,
	output logic                   has_byte,
	output logic                   run_last,
	output logic                   text_done,
	output logic                   decode_error,
	output logic [OUT_COUNT_W-1:0] byte_count
);

	qstat_t qstat;
	job_t   push_job, head;
	logic   push, pop;

	bbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.symbol      (symbol),
		.end_of_text (end_of_text),
		.qstat       (qstat),
		.push        (push),
		.push_job    (push_job)
	);

	bbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	bbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.run_last     (run_last),
		.text_done    (text_done),
		.decode_error (decode_error),
		.byte_count   (byte_count)
	);

	`BBD_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !qstat.full, "job pushed into full queue")
	`BBD_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !qstat.empty, "job popped from empty queue")
	`BBD_ASSERT_NOW(a_empty_is_end, clk, arst_n, out_valid && !has_byte, run_last && text_done, "byteless result is not a closing end result")
	`BBD_ASSERT_NOW(a_mid_quiet, clk, arst_n, out_valid && !(text_done && run_last), !decode_error && byte_count == '0, "status on a non-closing result")

endmodule

// ===== bench/base16_base64_decoder_core_tb.sv =====
// Self-checking testbench for the base16/base64 decoder core.
`timescale 1ns / 1ps

module base16_base64_decoder_core_tb import bbd_pkg::*; ;

	localparam int CLK_HALF       = 4;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int SQUEEZE_CYCLES = 200;
	localparam int RANDOM_ITEMS   = 30;

	typedef struct packed {
		logic [7:0] symbol;
		logic       eot;
	} char_item_t;

	typedef struct packed {
		logic [7:0]             data;
		logic                   has;
		logic                   last;
		logic                   done;
		logic                   err;
		logic [OUT_COUNT_W-1:0] count;
	} dec_result_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_wr_en    = 1'b0;
	logic                   cfg_wr_data  = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [7:0]             symbol       = 8'h00;
	logic                   end_of_text  = 1'b0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic [7:0]             data_byte;
	logic                   has_byte;
	logic                   run_last;
	logic                   text_done;
	logic                   decode_error;
	logic [OUT_COUNT_W-1:0] byte_count;

	base16_base64_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.symbol       (symbol),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.run_last     (run_last),
		.text_done    (text_done),
		.decode_error (decode_error),
		.byte_count   (byte_count)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Stimulus and expectation stores
	char_item_t  text_q[$];
	dec_result_t due_results[$];
	int          queued_chars = 0;
	int          err_count    = 0;
	int          cycle_count  = 0;

	// Decoder state as seen from outside
	logic                   mode_now = MODE_HEX;
	logic [1:0]             txt_phase = '0;
	logic [23:0]            txt_acc   = '0;
	logic                   txt_pad   = 1'b0;
	logic                   txt_bad   = 1'b0;
	logic [COUNT_WIDTH-1:0] txt_bytes = '0;

	logic in_idle_en  = 1'b1;
	logic out_idle_en = 1'b1;
	logic hold_req    = 1'b0;
	logic hold_on;
	int   hold_cnt;
	int   in_gap;
	int   out_gap;
	char_item_t next_item;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function automatic int sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return c - "A";
		if (c >= "a" && c <= "z") return c - "a" + 26;
		if (c >= "0" && c <= "9") return c - "0" + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		return -1;
	endfunction

	function automatic void bump_count();
		if (txt_bytes != '1)
			txt_bytes = txt_bytes + 1'b1;
	endfunction

	function automatic void add_due(input logic [7:0] b, input logic has, input logic last,
			input logic done, input logic err, input logic [COUNT_WIDTH-1:0] cnt);
		dec_result_t r;
		r.data  = b;
		r.has   = has;
		r.last  = last;
		r.done  = done;
		r.err   = err;
		r.count = OUT_COUNT_W'(cnt);
		due_results.push_back(r);
	endfunction

	// Advance the decoder state by one accepted character and queue what it emits.
	function automatic void decode_symbol(input logic [7:0] c, input logic eot);
		int         v;
		int         nf;
		logic       err;
		logic [7:0] flush [2];
		nf = 0;
		if (eot) begin
			err = txt_bad;
			if (!err) begin
				if (mode_now == MODE_HEX) begin
					err = (txt_phase != 2'd0);
				end else begin
					case (txt_phase)
						2'd1: err = 1'b1;
						2'd2: begin
							flush[0] = txt_acc[11:4];
							nf = 1;
						end
						2'd3: begin
							flush[0] = txt_acc[17:10];
							flush[1] = txt_acc[9:2];
							nf = 2;
						end
						default: ;
					endcase
				end
			end
			for (int k = 0; k < nf; k++)
				bump_count();
			if (nf == 0)
				add_due(8'h00, 1'b0, 1'b1, 1'b1, err, txt_bytes);
			for (int k = 0; k < nf; k++) begin
				if (k == nf - 1)
					add_due(flush[k], 1'b1, 1'b1, 1'b1, err, txt_bytes);
				else
					add_due(flush[k], 1'b1, 1'b0, 1'b1, 1'b0, '0);
			end
			txt_phase = '0;
			txt_acc   = '0;
			txt_pad   = 1'b0;
			txt_bad   = 1'b0;
			txt_bytes = '0;
			return;
		end
		if (txt_bad || txt_pad)
			return;
		if (mode_now == MODE_HEX) begin
			v = hex_digit(c);
			if (v < 0) begin
				txt_bad = 1'b1;
			end else if (txt_phase == 2'd0) begin
				txt_acc   = 24'(v);
				txt_phase = 2'd1;
			end else begin
				// any leftover phase counts as a held high nibble
				add_due({txt_acc[3:0], 4'(v)}, 1'b1, 1'b1, 1'b0, 1'b0, '0);
				bump_count();
				txt_phase = '0;
				txt_acc   = '0;
			end
		end else if (c == CHAR_PAD) begin
			txt_pad = 1'b1;
		end else begin
			v = sextet(c);
			if (v < 0) begin
				txt_bad = 1'b1;
			end else begin
				txt_acc = {txt_acc[17:0], 6'(v)};
				if (txt_phase != 2'd3) begin
					txt_phase = txt_phase + 2'd1;
				end else begin
					add_due(txt_acc[23:16], 1'b1, 1'b0, 1'b0, 1'b0, '0);
					add_due(txt_acc[15:8], 1'b1, 1'b0, 1'b0, 1'b0, '0);
					add_due(txt_acc[7:0], 1'b1, 1'b1, 1'b0, 1'b0, '0);
					bump_count();
					bump_count();
					bump_count();
					txt_phase = '0;
					txt_acc   = '0;
				end
			end
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(3, 1);
		if (r < 95) return $urandom_range(8, 4);
		return $urandom_range(40, 12);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	// Input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			symbol      <= 8'h00;
			end_of_text <= 1'b0;
			in_gap      <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_symbol(symbol, end_of_text);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap   <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (text_q.size() != 0) begin
					next_item = text_q.pop_front();
					in_valid    <= 1'b1;
					symbol      <= next_item.symbol;
					end_of_text <= next_item.eot;
					if (in_idle_en && $urandom_range(3) == 0)
						in_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, so the core backs up and drops in_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_on  <= 1'b0;
		end else if (!hold_req) begin
			hold_cnt <= 0;
			hold_on  <= 1'b0;
		end else if (hold_cnt < SQUEEZE_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			hold_on  <= 1'b1;
		end else begin
			hold_on <= 1'b0;
		end
	end

	// Output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, got byte %0h count %0h",
						$time, data_byte, byte_count);
					err_count++;
				end else begin
					check_field("data_byte", due_results[0].data, data_byte);
					check_field("has_byte", due_results[0].has, has_byte);
					check_field("run_last", due_results[0].last, run_last);
					check_field("text_done", due_results[0].done, text_done);
					check_field("decode_error", due_results[0].err, decode_error);
					check_field("byte_count", due_results[0].count, byte_count);
					void'(due_results.pop_front());
				end
			end
			if (out_gap > 0) begin
				out_gap   <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !hold_on;
				if (out_idle_en && $urandom_range(3) == 0)
					out_gap <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void push_sym(input logic [7:0] c);
		char_item_t it;
		it.symbol = c;
		it.eot    = 1'b0;
		text_q.push_back(it);
		queued_chars++;
	endfunction

	function automatic void push_eot();
		char_item_t it;
		it.symbol = 8'($urandom_range(255));
		it.eot    = 1'b1;
		text_q.push_back(it);
		queued_chars++;
	endfunction

	function automatic void push_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			push_sym(s[i]);
		if (close)
			push_eot();
	endfunction

	function automatic logic [7:0] b64_char(input int v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		return (v == 62) ? "+" : "/";
	endfunction

	function automatic logic [7:0] good_char();
		int n;
		if (mode_now == MODE_B64)
			return b64_char($urandom_range(63));
		n = $urandom_range(15);
		if (n < 10) return 8'("0" + n);
		return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
	endfunction

	// One random text in the current mode, closed by an end of text.
	function automatic void random_text();
		int kind;
		int n;
		kind = $urandom_range(9);
		if (kind < 6) begin
			n = (mode_now == MODE_HEX) ? 2 * $urandom_range(6) : $urandom_range(10);
			for (int i = 0; i < n; i++)
				push_sym(good_char());
			if (mode_now == MODE_B64 && (n % 4) != 0 && $urandom_range(1)) begin
				push_sym(CHAR_PAD);
				if ((n % 4) == 2)
					push_sym(CHAR_PAD);
			end
		end else if (kind < 8) begin
			n = $urandom_range(5);
			for (int i = 0; i < n; i++)
				push_sym(good_char());
			case ($urandom_range(2))
				0: push_sym(8'($urandom_range(255)));
				1: push_sym(CHAR_PAD);
				default: ;
			endcase
			n = $urandom_range(3);
			for (int i = 0; i < n; i++)
				push_sym($urandom_range(1) ? good_char() : 8'($urandom_range(255)));
		end else begin
			n = $urandom_range(8, 1);
			for (int i = 0; i < n; i++)
				push_sym(8'($urandom_range(255)));
		end
		push_eot();
	endfunction

	task automatic wait_idle();
		while (text_q.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		// characters that emit nothing may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_now = m;
		@(negedge clk);
	endtask

	int rand_stop;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hex: extremes of both cases, odd length, invalid digit after a byte
		write_mode(MODE_HEX);
		push_text("00Ffa9", 1);
		push_text("7", 1);
		push_text("12G3", 1);

		// base64: alphabet edges, pad then ignored garbage, partial quanta
		write_mode(MODE_B64);
		push_text("A/+za9=~", 1);
		push_text("ZZZ", 1);
		push_text("x", 1);
		push_text("Q8", 0);
		// switch to hex with two sextets still held
		write_mode(MODE_HEX);
		push_text("5", 1);

		write_mode(MODE_B64);
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		hold_req    = 1'b1;
		for (int i = 0; i < 32; i++)
			push_sym(good_char());
		push_eot();
		wait_idle();
		@(negedge clk);
		hold_req = 1'b0;

		rand_stop = queued_chars + RANDOM_ITEMS;
		while (queued_chars < rand_stop) begin
			write_mode(logic'($urandom_range(1)));
			in_idle_en  = ($urandom_range(3) != 0);
			out_idle_en = ($urandom_range(3) != 0);
			repeat ($urandom_range(4, 1))
				random_text();
		end

		wait_idle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
